// ----- hw/rtl/ptp_pkg.sv -----
// shared types, widths and helper functions for the point-to-plane pose residual block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptp_pkg;

   localparam int DATA_W        = 32;
   localparam int QF            = 30;
   localparam int FRAC_BITS_DEF = 16;
   localparam int QP_W          = 34;
   localparam int R_W           = 38;
   localparam int WIDE_W        = 48;
   localparam int PIPE_STAGES   = 10;
   localparam int CSR_IDX_W     = 3;
   localparam int NUM_LANES     = 7;
   localparam int SPLIT_W       = 24;
   localparam int PP_W          = DATA_W + SPLIT_W + 1;

   typedef logic signed [DATA_W-1:0] s32_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [R_W-1:0]    rval_type;
   typedef logic signed [PP_W-1:0]   pp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WEIGHT, REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z,
      REG_TARGET_X, REG_TARGET_Y, REG_TARGET_Z
   } reg_idx_type;

   localparam logic [DATA_W-1:0] WEIGHT_RST   = DATA_W'(1) << FRAC_BITS_DEF;
   localparam logic [DATA_W-1:0] NORMAL_Z_RST = DATA_W'(1) << QF;

   typedef struct packed {
      s32_type pos_x;
      s32_type pos_y;
      s32_type pos_z;
      s32_type quat_w;
      s32_type quat_x;
      s32_type quat_y;
      s32_type quat_z;
      s32_type local_x;
      s32_type local_y;
      s32_type local_z;
   } req_type;

   typedef struct packed {
      s32_type residual;
      s32_type jac_tx;
      s32_type jac_ty;
      s32_type jac_tz;
      s32_type jac_rx;
      s32_type jac_ry;
      s32_type jac_rz;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [DATA_W-1:0]    data;
   } csr_type;

   // a times the low part of b, low part unsigned
   function automatic pp_type pp_lo(input s32_type a, input wide_type b);
      return a * $signed({1'b0, b[SPLIT_W-1:0]});
   endfunction

   // a times the high part of b
   function automatic pp_type pp_hi(input s32_type a, input wide_type b);
      logic signed [SPLIT_W-1:0] h;
      h = b[WIDE_W-1:SPLIT_W];
      return a * h;
   endfunction

   // floor(a * b / 2^30) from the two partial products
   function automatic wide_type pp_join(input pp_type hi, input pp_type lo);
      logic signed [WIDE_W+DATA_W:0] sum;
      sum = ((WIDE_W+DATA_W+1)'(hi) <<< SPLIT_W) + (WIDE_W+DATA_W+1)'(lo);
      return sum[QF+WIDE_W-1:QF];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ptp_if.sv -----
// valid/ready channel interfaces for request, response and register writes
// depends on ptp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ptp_req_if import ptp_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface ptp_rsp_if import ptp_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface ptp_csr_if import ptp_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ptp_rot.sv -----
// two-stage quaternion to rotation matrix, point and translation carried along
// depends on ptp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptp_rot import ptp_pkg::*; (
   input  wire logic     clock,
   input  wire logic     en,
   input  wire req_type  req,
   output rval_type      rot_out [3][3],
   output s32_type       p_out [3],
   output s32_type       t_out [3]
);

   function automatic logic signed [QP_W-1:0] qprod(input s32_type a, input s32_type b);
      logic signed [2*DATA_W-1:0] prod;
      prod = a * b;
      return prod[2*DATA_W-1:QF];
   endfunction

   localparam rval_type ONE = R_W'(1) <<< QF;

   logic signed [QP_W-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   s32_type  p1_ff [3];
   s32_type  t1_ff [3];
   rval_type rot_ff [3][3];
   s32_type  p2_ff [3];
   s32_type  t2_ff [3];
   rval_type xx, yy, zz, xy, xz, yz, wx, wy, wz;

   always_comb begin
      xx = R_W'(xx_ff); yy = R_W'(yy_ff); zz = R_W'(zz_ff);
      xy = R_W'(xy_ff); xz = R_W'(xz_ff); yz = R_W'(yz_ff);
      wx = R_W'(wx_ff); wy = R_W'(wy_ff); wz = R_W'(wz_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff <= qprod(req.quat_x, req.quat_x);
         yy_ff <= qprod(req.quat_y, req.quat_y);
         zz_ff <= qprod(req.quat_z, req.quat_z);
         xy_ff <= qprod(req.quat_x, req.quat_y);
         xz_ff <= qprod(req.quat_x, req.quat_z);
         yz_ff <= qprod(req.quat_y, req.quat_z);
         wx_ff <= qprod(req.quat_w, req.quat_x);
         wy_ff <= qprod(req.quat_w, req.quat_y);
         wz_ff <= qprod(req.quat_w, req.quat_z);
         p1_ff[0] <= req.local_x; p1_ff[1] <= req.local_y; p1_ff[2] <= req.local_z;
         t1_ff[0] <= req.pos_x;   t1_ff[1] <= req.pos_y;   t1_ff[2] <= req.pos_z;

         rot_ff[0][0] <= ONE - 2 * (yy + zz);
         rot_ff[0][1] <= 2 * (xy - wz);
         rot_ff[0][2] <= 2 * (xz + wy);
         rot_ff[1][0] <= 2 * (xy + wz);
         rot_ff[1][1] <= ONE - 2 * (xx + zz);
         rot_ff[1][2] <= 2 * (yz - wx);
         rot_ff[2][0] <= 2 * (xz - wy);
         rot_ff[2][1] <= 2 * (yz + wx);
         rot_ff[2][2] <= ONE - 2 * (xx + yy);
         p2_ff <= p1_ff;
         t2_ff <= t1_ff;
      end
   end

   assign rot_out = rot_ff;
   assign p_out   = p2_ff;
   assign t_out   = t2_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ptp_xform.sv -----
// six-stage transform: rotated point, plane distance, normal in body frame, cross product
// depends on ptp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptp_xform import ptp_pkg::*; (
   input  wire logic     clock,
   input  wire logic     en,
   input  wire rval_type rot [3][3],
   input  wire s32_type  p_in [3],
   input  wire s32_type  t_in [3],
   input  wire s32_type  normal [3],
   input  wire s32_type  target [3],
   output wide_type      r_out,
   output wide_type      negc_out [3]
);

   pp_type   gh_ff [3][3];
   pp_type   gl_ff [3][3];
   pp_type   mh_ff [3][3];
   pp_type   ml_ff [3][3];
   wide_type g_ff [3][3];
   wide_type mm_ff [3][3];
   s32_type  p3_ff [3];
   s32_type  t3_ff [3];
   s32_type  p4_ff [3];
   s32_type  t4_ff [3];
   wide_type d_ff [3];
   wide_type m_ff [3];
   s32_type  p5_ff [3];
   pp_type   rh_ff [3];
   pp_type   rl_ff [3];
   pp_type   ch_ff [6];
   pp_type   cl_ff [6];
   wide_type rn_ff [3];
   wide_type cp_ff [6];
   wide_type r_ff;
   wide_type negc_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         // split products of point and normal with the rotation matrix
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               gh_ff[i][j] <= pp_hi(p_in[j], WIDE_W'(rot[i][j]));
               gl_ff[i][j] <= pp_lo(p_in[j], WIDE_W'(rot[i][j]));
               mh_ff[i][j] <= pp_hi(normal[i], WIDE_W'(rot[i][j]));
               ml_ff[i][j] <= pp_lo(normal[i], WIDE_W'(rot[i][j]));
            end
         end
         p3_ff <= p_in;
         t3_ff <= t_in;

         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               g_ff[i][j]  <= pp_join(gh_ff[i][j], gl_ff[i][j]);
               mm_ff[i][j] <= pp_join(mh_ff[i][j], ml_ff[i][j]);
            end
         end
         p4_ff <= p3_ff;
         t4_ff <= t3_ff;

         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= g_ff[i][0] + g_ff[i][1] + g_ff[i][2]
                       + WIDE_W'(t4_ff[i]) - WIDE_W'(target[i]);
            m_ff[i] <= mm_ff[0][i] + mm_ff[1][i] + mm_ff[2][i];
         end
         p5_ff <= p4_ff;

         for (int i = 0; i < 3; i++) begin
            rh_ff[i] <= pp_hi(normal[i], d_ff[i]);
            rl_ff[i] <= pp_lo(normal[i], d_ff[i]);
         end
         ch_ff[0] <= pp_hi(p5_ff[2], m_ff[1]); cl_ff[0] <= pp_lo(p5_ff[2], m_ff[1]);
         ch_ff[1] <= pp_hi(p5_ff[1], m_ff[2]); cl_ff[1] <= pp_lo(p5_ff[1], m_ff[2]);
         ch_ff[2] <= pp_hi(p5_ff[0], m_ff[2]); cl_ff[2] <= pp_lo(p5_ff[0], m_ff[2]);
         ch_ff[3] <= pp_hi(p5_ff[2], m_ff[0]); cl_ff[3] <= pp_lo(p5_ff[2], m_ff[0]);
         ch_ff[4] <= pp_hi(p5_ff[1], m_ff[0]); cl_ff[4] <= pp_lo(p5_ff[1], m_ff[0]);
         ch_ff[5] <= pp_hi(p5_ff[0], m_ff[1]); cl_ff[5] <= pp_lo(p5_ff[0], m_ff[1]);

         for (int i = 0; i < 3; i++)
            rn_ff[i] <= pp_join(rh_ff[i], rl_ff[i]);
         for (int k = 0; k < 6; k++)
            cp_ff[k] <= pp_join(ch_ff[k], cl_ff[k]);

         r_ff       <= rn_ff[0] + rn_ff[1] + rn_ff[2];
         negc_ff[0] <= cp_ff[1] - cp_ff[0];
         negc_ff[1] <= cp_ff[3] - cp_ff[2];
         negc_ff[2] <= cp_ff[5] - cp_ff[4];
      end
   end

   assign r_out    = r_ff;
   assign negc_out = negc_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ptp_wscale.sv -----
// two-stage weighting: split product by the weight, floor shift and 32-bit saturation
// depends on ptp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptp_wscale import ptp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [DATA_W-1:0] weight,
   input  wire wide_type          v_in [NUM_LANES],
   output s32_type                res_out [NUM_LANES]
);

   localparam int LO_W = 24;
   localparam int HI_W = WIDE_W - LO_W;
   localparam int SW   = DATA_W + WIDE_W + 2;

   logic [DATA_W+LO_W-1:0]          plo_ff [NUM_LANES];
   logic signed [DATA_W+HI_W:0]     phi_ff [NUM_LANES];
   s32_type                         res_ff [NUM_LANES];

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      localparam int SH = (g >= 1 && g <= 3) ? QF : FRAC_BITS;
      logic signed [SW-1:0]   full;
      logic signed [SW-1:0]   shifted;
      logic signed [HI_W-1:0] hi;

      assign hi      = v_in[g][WIDE_W-1:LO_W];
      assign full    = (SW'(phi_ff[g]) <<< LO_W) + SW'($signed({1'b0, plo_ff[g]}));
      assign shifted = full >>> SH;

      always_ff @(posedge clock) begin
         if (en) begin
            plo_ff[g] <= weight * v_in[g][LO_W-1:0];
            phi_ff[g] <= $signed({1'b0, weight}) * hi;
            if (shifted[SW-1:DATA_W-1] == '0 || shifted[SW-1:DATA_W-1] == '1)
               res_ff[g] <= shifted[DATA_W-1:0];
            else if (shifted[SW-1])
               res_ff[g] <= {1'b1, {(DATA_W-1){1'b0}}};
            else
               res_ff[g] <= {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
   end

   assign res_out = res_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/point_to_plane_pose_residual_top.sv -----
// top level: register file, pipeline control and the three datapath sections
// depends on ptp_pkg, ptp_if, ptp_rot, ptp_xform, ptp_wscale
//
// channel  | dir | payload                                   | transfer when
// req_bus  | in  | pose (pos, quat) and body point (local)   | valid && ready
// rsp_bus  | out | residual and six jacobian entries         | valid && ready
// csr_bus  | in  | register index and write data             | valid (ready held high)
//
// ten register stages, one item per cycle while the output is not stalled
// stages: quaternion products, rotation matrix, six transform stages, two weighting stages
// reset clears the stage valid bits and loads register defaults
// a stalled output freezes every stage at once, so nothing is dropped or repeated
`timescale 1ns / 1ps
`default_nettype none

module point_to_plane_pose_residual_top import ptp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   ptp_req_if.sink   req_bus,
   ptp_rsp_if.source rsp_bus,
   ptp_csr_if.sink   csr_bus
);

   logic [DATA_W-1:0]      weight_ff;
   s32_type                normal_ff [3];
   s32_type                target_ff [3];
   logic [PIPE_STAGES-1:0] vld_ff;
   logic                   en;
   rval_type               rot [3][3];
   s32_type                p2 [3];
   s32_type                t2 [3];
   wide_type               r6;
   wide_type               negc6 [3];
   wide_type               lanes [NUM_LANES];
   s32_type                res [NUM_LANES];

   assign en            = !vld_ff[PIPE_STAGES-1] || rsp_bus.ready;
   assign req_bus.ready = en;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= DATA_W'(1) << FRAC_BITS;
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= NORMAL_Z_RST;
         target_ff[0] <= '0;
         target_ff[1] <= '0;
         target_ff[2] <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.data.index)
            REG_WEIGHT:   weight_ff    <= csr_bus.data.data;
            REG_NORMAL_X: normal_ff[0] <= csr_bus.data.data;
            REG_NORMAL_Y: normal_ff[1] <= csr_bus.data.data;
            REG_NORMAL_Z: normal_ff[2] <= csr_bus.data.data;
            REG_TARGET_X: target_ff[0] <= csr_bus.data.data;
            REG_TARGET_Y: target_ff[1] <= csr_bus.data.data;
            REG_TARGET_Z: target_ff[2] <= csr_bus.data.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_STAGES-2:0], req_bus.valid};
      end
   end

   ptp_rot u_rot (
      .clock   (clock),
      .en      (en),
      .req     (req_bus.data),
      .rot_out (rot),
      .p_out   (p2),
      .t_out   (t2)
   );

   ptp_xform u_xform (
      .clock    (clock),
      .en       (en),
      .rot      (rot),
      .p_in     (p2),
      .t_in     (t2),
      .normal   (normal_ff),
      .target   (target_ff),
      .r_out    (r6),
      .negc_out (negc6)
   );

   assign lanes[0] = r6;
   assign lanes[1] = WIDE_W'(normal_ff[0]);
   assign lanes[2] = WIDE_W'(normal_ff[1]);
   assign lanes[3] = WIDE_W'(normal_ff[2]);
   assign lanes[4] = negc6[0];
   assign lanes[5] = negc6[1];
   assign lanes[6] = negc6[2];

   ptp_wscale #(.FRAC_BITS(FRAC_BITS)) u_wscale (
      .clock   (clock),
      .en      (en),
      .weight  (weight_ff),
      .v_in    (lanes),
      .res_out (res)
   );

   assign rsp_bus.valid         = vld_ff[PIPE_STAGES-1];
   assign rsp_bus.data.residual = res[0];
   assign rsp_bus.data.jac_tx   = res[1];
   assign rsp_bus.data.jac_ty   = res[2];
   assign rsp_bus.data.jac_tz   = res[3];
   assign rsp_bus.data.jac_rx   = res[4];
   assign rsp_bus.data.jac_ry   = res[5];
   assign rsp_bus.data.jac_rz   = res[6];

endmodule

`default_nettype wire
